// ----- rtl/dvst_pkg.sv -----
// Shared types, codes and helpers for the deduplicating vector scan top-k block.
// Used by dvst_cell, dvst_visit_map and dedup_vector_scan_topk_unit.
`timescale 1ns / 1ps
`default_nettype none
package dvst_pkg;

  localparam int WORD_SHIFT = 5;
  localparam int WORD_MASK  = 31;

  localparam logic signed [47:0] DIST_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] DIST_MIN = 48'sh8000_0000_0000;

  typedef enum logic [1:0] {
    OP_NEW_QUERY  = 2'd0,
    OP_QUERY_COMP = 2'd1,
    OP_CAND_COMP  = 2'd2,
    OP_DRAIN      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_METRIC = 2'd0,
    REG_DIMS   = 2'd1,
    REG_K      = 2'd2,
    REG_DEDUP  = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_ACC,
    ST_INS_SCAN,
    ST_INS_WRITE,
    ST_RESULT,
    ST_DR_SCAN,
    ST_DR_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [6:0]         dim_index;
    logic signed [15:0] value;
    logic [15:0]        vector_id;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        result_id;
    logic signed [47:0] result_distance;
    logic               result_valid;
    logic               inserted;
    logic               skipped;
    logic [31:0]        skip_total;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic signed [47:0] score;
    logic [15:0]        id;
    logic               valid;
    logic               mark;
  } cell_t;

  typedef struct packed {
    logic shift;
    logic clear;
    logic load;
    logic set_mark;
    logic clr_mark;
  } cell_ctl_t;

  typedef struct packed {
    logic clear_start;
    logic rd_en;
    logic wr_en;
  } vm_ctl_t;

  function automatic logic better(input logic metric, input logic signed [47:0] a,
                                  input logic signed [47:0] b);
    return metric ? (a > b) : (a < b);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/dvst_cell.sv -----
// One slot of the top-k store; part of a rotating chain of cells.
// Depends on dvst_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dvst_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dvst_pkg::cell_ctl_t ctl,
  input  wire dvst_pkg::cell_t    nb,
  input  wire dvst_pkg::cell_t    wd,
  output dvst_pkg::cell_t         q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
      q.mark  <= 1'b0;
    end else if (ctl.clear) begin
      q <= '0;
    end else if (ctl.shift) begin
      q <= nb;
    end else begin
      if (ctl.load) begin
        q.score <= wd.score;
        q.id    <= wd.id;
        q.valid <= 1'b1;
      end
      if (ctl.clr_mark) begin
        q.mark <= 1'b0;
      end else if (ctl.set_mark) begin
        q.mark <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/dvst_visit_map.sv -----
// Visited-id bitmap memory, 32 bits per word, with a one-word-per-cycle clearing pass.
// Depends on dvst_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dvst_visit_map #(
  parameter int NTOTAL = 65536
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire dvst_pkg::vm_ctl_t ctl,
  input  wire logic [((((NTOTAL+31)/32) > 1) ? $clog2((NTOTAL+31)/32) : 1)-1:0] rd_addr,
  input  wire logic [((((NTOTAL+31)/32) > 1) ? $clog2((NTOTAL+31)/32) : 1)-1:0] wr_addr,
  input  wire logic [31:0]     wr_data,
  output logic [31:0]          rd_data,
  output logic                 busy
);

  localparam int MAP_WORDS = (NTOTAL + 31) / 32;
  localparam int MWB       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  logic [31:0]    mem [MAP_WORDS];
  logic [MWB-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (ctl.clear_start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == MWB'(MAP_WORDS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[cnt] <= '0;
    end else if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/dedup_vector_scan_topk_unit.sv -----
// Nearest-vector scan with visited-id dedup and a top-k store (top level).
// Depends on dvst_pkg, dvst_cell, dvst_visit_map.
//
//   channel  handshake              payload
//   req      req_valid/req_ready    req   (dvst_pkg::in_item_t)
//   rsp      rsp_valid/rsp_ready    rsp   (dvst_pkg::out_item_t)
//   cfg      cfg_valid/cfg_ready    cfg_index, cfg_data
//
// Candidate component: FETCH and ACC; the last one then makes an insert pass around
// the cell ring (INS_SCAN, INS_WRITE) unless dropped as a duplicate. Drain: one scan
// round of the ring per result. New query and reset start a clearing pass over the bitmap;
// req_ready is low during it. A result waits while the rsp register still holds an
// unaccepted item, and req_ready stays low meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module dedup_vector_scan_topk_unit #(
  parameter int DIM    = 128,
  parameter int TOPK   = 16,
  parameter int NTOTAL = 65536
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire dvst_pkg::in_item_t req,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  output dvst_pkg::out_item_t     rsp,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [7:0]         cfg_data
);

  localparam int QAW       = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int KW        = $clog2(TOPK + 1);
  localparam int SW        = (TOPK > 1) ? $clog2(TOPK) : 1;
  localparam int MAP_WORDS = (NTOTAL + 31) / 32;
  localparam int MWB       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  logic       metric_kind;
  logic [7:0] dims_used;
  logic [4:0] k_used;
  logic       dedup_enable;

  dvst_pkg::state_t   state, state_next;
  dvst_pkg::in_item_t item;
  logic signed [47:0] acc;
  logic               dropped;
  logic [31:0]        skip_count;
  logic signed [33:0] prod;
  logic signed [15:0] qrd;
  logic               inserted;
  logic [KW-1:0]      scnt;
  logic [KW-1:0]      rank;
  logic               free_found;
  logic [SW-1:0]      free_idx;
  logic [SW-1:0]      wid;
  logic signed [47:0] wdist;
  logic [15:0]        wcid;
  logic               b_ok;
  logic [SW-1:0]      bidx;
  dvst_pkg::cell_t    best;

  logic signed [15:0] qmem [DIM];

  logic [KW-1:0]      kk;
  logic [7:0]         dims;
  logic               acc_in;
  logic               rsp_free;
  logic               rsp_load;
  dvst_pkg::out_item_t rsp_data;
  logic               in_k;
  logic               ins_ok;
  logic               dedup_hit;
  logic signed [16:0] diff;
  logic signed [16:0] opa, opb;
  logic signed [48:0] sum;
  logic signed [47:0] sum_sat;
  logic [QAW-1:0]     qaddr;

  dvst_pkg::cell_ctl_t cctl;
  logic [SW-1:0]       widx;
  dvst_pkg::cell_t     wd;
  dvst_pkg::cell_t     cq [TOPK];
  dvst_pkg::cell_t     head;

  dvst_pkg::vm_ctl_t vctl;
  logic [31:0]       vrd;
  logic              vm_busy;

  assign cfg_ready = 1'b1;
  assign kk   = (k_used == 5'd0) ? KW'(1) :
                ((32'(k_used) > TOPK) ? KW'(TOPK) : KW'(k_used));
  assign dims = (dims_used == 8'd0) ? 8'd1 :
                ((32'(dims_used) > DIM) ? 8'(DIM) : dims_used);
  assign acc_in    = req_valid && req_ready;
  assign rsp_free  = !rsp_valid || rsp_ready;
  assign head      = cq[0];
  assign in_k      = scnt < kk;
  assign ins_ok    = free_found || dvst_pkg::better(metric_kind, acc, wdist);
  assign dedup_hit = (item.dim_index == 7'd0) && dedup_enable &&
                     (32'(item.vector_id) < NTOTAL);
  assign diff      = 17'(qrd) - 17'(item.value);
  assign opa       = metric_kind ? 17'(qrd) : diff;
  assign opb       = metric_kind ? 17'(item.value) : diff;
  assign sum       = 49'(acc) + 49'(prod);
  assign sum_sat   = (sum[48] != sum[47]) ? (sum[48] ? dvst_pkg::DIST_MIN : dvst_pkg::DIST_MAX)
                                          : sum[47:0];
  assign qaddr     = QAW'(req.dim_index);

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      metric_kind  <= 1'b0;
      dims_used    <= 8'd128;
      k_used       <= 5'd16;
      dedup_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (dvst_pkg::reg_idx_t'(cfg_index))
        dvst_pkg::REG_METRIC: metric_kind  <= cfg_data[0];
        dvst_pkg::REG_DIMS:   dims_used    <= cfg_data;
        dvst_pkg::REG_K:      k_used       <= cfg_data[4:0];
        dvst_pkg::REG_DEDUP:  dedup_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // query store
  always_ff @(posedge clk) begin
    if (acc_in && req.operation == dvst_pkg::OP_QUERY_COMP && 32'(req.dim_index) < DIM) begin
      qmem[qaddr] <= req.value;
    end
    if (acc_in && req.operation == dvst_pkg::OP_CAND_COMP) begin
      qrd <= qmem[qaddr];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      dvst_pkg::ST_IDLE: begin
        if (acc_in) begin
          if (req.operation == dvst_pkg::OP_CAND_COMP && 8'(req.dim_index) < dims) begin
            state_next = dvst_pkg::ST_FETCH;
          end else if (req.operation == dvst_pkg::OP_DRAIN) begin
            state_next = dvst_pkg::ST_DR_SCAN;
          end
        end
      end
      dvst_pkg::ST_FETCH: state_next = dvst_pkg::ST_ACC;
      dvst_pkg::ST_ACC: begin
        if (8'(item.dim_index) == dims - 8'd1) begin
          state_next = dropped ? dvst_pkg::ST_RESULT : dvst_pkg::ST_INS_SCAN;
        end else begin
          state_next = dvst_pkg::ST_IDLE;
        end
      end
      dvst_pkg::ST_INS_SCAN: begin
        if (scnt == KW'(TOPK - 1)) state_next = dvst_pkg::ST_INS_WRITE;
      end
      dvst_pkg::ST_INS_WRITE: state_next = dvst_pkg::ST_RESULT;
      dvst_pkg::ST_RESULT: begin
        if (rsp_free) state_next = dvst_pkg::ST_IDLE;
      end
      dvst_pkg::ST_DR_SCAN: begin
        if (scnt == KW'(TOPK - 1)) state_next = dvst_pkg::ST_DR_OUT;
      end
      dvst_pkg::ST_DR_OUT: begin
        if (rsp_free) begin
          state_next = (rank == kk - KW'(1)) ? dvst_pkg::ST_IDLE : dvst_pkg::ST_DR_SCAN;
        end
      end
      default: state_next = dvst_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    req_ready        = (state == dvst_pkg::ST_IDLE) && !vm_busy;
    cctl             = '0;
    cctl.shift       = (state == dvst_pkg::ST_INS_SCAN) || (state == dvst_pkg::ST_DR_SCAN);
    cctl.clear       = acc_in && req.operation == dvst_pkg::OP_NEW_QUERY;
    cctl.clr_mark    = acc_in && req.operation == dvst_pkg::OP_DRAIN;
    cctl.load        = (state == dvst_pkg::ST_INS_WRITE) && ins_ok;
    cctl.set_mark    = (state == dvst_pkg::ST_DR_OUT) && rsp_free;
    widx             = (state == dvst_pkg::ST_DR_OUT) ? bidx : (free_found ? free_idx : wid);
    wd               = '0;
    wd.score         = acc;
    wd.id            = item.vector_id;
    vctl.clear_start = cctl.clear;
    vctl.rd_en       = acc_in && req.operation == dvst_pkg::OP_CAND_COMP;
    vctl.wr_en       = (state == dvst_pkg::ST_FETCH) && dedup_hit;
    rsp_load         = ((state == dvst_pkg::ST_RESULT) || (state == dvst_pkg::ST_DR_OUT)) &&
                       rsp_free;
    rsp_data            = '0;
    rsp_data.skip_total = skip_count;
    if (state == dvst_pkg::ST_RESULT) begin
      rsp_data.result_id       = item.vector_id;
      rsp_data.result_distance = dropped ? 48'sd0 : acc;
      rsp_data.inserted        = inserted && !dropped;
      rsp_data.skipped         = dropped;
      rsp_data.last            = 1'b1;
    end else begin
      rsp_data.result_id       = best.valid ? best.id : 16'd0;
      rsp_data.result_distance = best.valid ? best.score : 48'sd0;
      rsp_data.result_valid    = best.valid;
      rsp_data.last            = (rank == kk - KW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= dvst_pkg::ST_IDLE;
      rsp_valid  <= 1'b0;
      skip_count <= '0;
      acc        <= '0;
      dropped    <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (cctl.clear) begin
        skip_count <= '0;
        acc        <= '0;
        dropped    <= 1'b0;
      end
      if (state == dvst_pkg::ST_FETCH && item.dim_index == 7'd0) begin
        acc     <= '0;
        dropped <= dedup_hit && vrd[item.vector_id[dvst_pkg::WORD_SHIFT-1:0]];
        if (dedup_hit && vrd[item.vector_id[dvst_pkg::WORD_SHIFT-1:0]] &&
            skip_count != 32'hFFFF_FFFF) begin
          skip_count <= skip_count + 32'd1;
        end
      end
      if (state == dvst_pkg::ST_ACC && !dropped) begin
        acc <= sum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) rsp <= rsp_data;
    if (acc_in) item <= req;
    if (state == dvst_pkg::ST_FETCH) prod <= opa * opb;
    if (state == dvst_pkg::ST_INS_WRITE) inserted <= ins_ok;
    if (acc_in && req.operation == dvst_pkg::OP_DRAIN) rank <= '0;
    if (state == dvst_pkg::ST_DR_OUT && rsp_free) rank <= rank + KW'(1);
    if ((state == dvst_pkg::ST_ACC) || (state == dvst_pkg::ST_DR_OUT) ||
        (state == dvst_pkg::ST_IDLE)) begin
      scnt <= '0;
    end else if (cctl.shift) begin
      scnt <= (scnt == KW'(TOPK - 1)) ? '0 : scnt + KW'(1);
    end
    if (state == dvst_pkg::ST_INS_SCAN) begin
      if (scnt == '0) free_found <= in_k && !head.valid;
      else if (in_k && !head.valid && !free_found) free_found <= 1'b1;
      if (in_k && !head.valid && (scnt == '0 || !free_found)) free_idx <= SW'(scnt);
      if (in_k && (scnt == '0 || dvst_pkg::better(metric_kind, wdist, head.score) ||
                   (wdist == head.score && head.id > wcid))) begin
        wid   <= SW'(scnt);
        wdist <= head.score;
        wcid  <= head.id;
      end
    end
    if (state == dvst_pkg::ST_DR_SCAN) begin
      if (in_k && !head.mark &&
          (scnt == '0 || !b_ok ||
           (head.valid != best.valid ? head.valid :
            (!head.valid ? 1'b0 :
             (head.score != best.score ?
              dvst_pkg::better(metric_kind, head.score, best.score) :
              (head.id < best.id)))))) begin
        b_ok <= 1'b1;
        bidx <= SW'(scnt);
        best <= head;
      end else if (scnt == '0) begin
        b_ok <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < TOPK; i++) begin : g_cell
    dvst_pkg::cell_ctl_t ci;
    always_comb begin
      ci          = cctl;
      ci.load     = cctl.load && (widx == SW'(i));
      ci.set_mark = cctl.set_mark && (widx == SW'(i));
    end
    dvst_cell u_cell (
      .clk (clk),
      .rst (rst),
      .ctl (ci),
      .nb  (cq[(i + 1) % TOPK]),
      .wd  (wd),
      .q   (cq[i])
    );
  end

  dvst_visit_map #(
    .NTOTAL (NTOTAL)
  ) u_visit_map (
    .clk     (clk),
    .rst     (rst),
    .ctl     (vctl),
    .rd_addr (MWB'(req.vector_id >> dvst_pkg::WORD_SHIFT)),
    .wr_addr (MWB'(item.vector_id >> dvst_pkg::WORD_SHIFT)),
    .wr_data (vrd | (32'd1 << (32'(item.vector_id) & dvst_pkg::WORD_MASK))),
    .rd_data (vrd),
    .busy    (vm_busy)
  );

  a_ring_home: assert property (@(posedge clk) disable iff (rst)
    (state == dvst_pkg::ST_INS_WRITE || state == dvst_pkg::ST_DR_OUT) |-> scnt == '0)
    else $error("cell ring not at home position");

  a_drain_pick: assert property (@(posedge clk) disable iff (rst)
    state == dvst_pkg::ST_DR_OUT |-> b_ok)
    else $error("drain round found no slot");

  a_clear_start: assert property (@(posedge clk) disable iff (rst)
    (acc_in && req.operation == dvst_pkg::OP_NEW_QUERY) |=> (vm_busy && !req_ready))
    else $error("bitmap clear not started");

  a_no_shift_wr: assert property (@(posedge clk) disable iff (rst)
    !(cctl.shift && (cctl.load || cctl.set_mark)))
    else $error("cell write during rotation");

endmodule
`default_nettype wire
